@@ rtl/sts_pkg.sv @@
// ----------------------------------------------------------------------------
// sts_pkg : shared types and constants of the sorted-table search core
// Holds the fixed field widths, the request kind codes and the controller
// state type.
// ----------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

  // Fixed port field widths
  localparam int ENTRY_INDEX_W = 10;
  localparam int KEY_VALUE_W   = 32;
  localparam int COUNT_W       = 11;
  localparam int POSITION_W    = 10;

  // Request kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

@@ rtl/sorted_table_binary_search_core.sv @@
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core : binary search over a sorted key table
// Keeps up to TABLE_DEPTH keys in one synchronous memory and answers search
// requests with a found flag and the position of the matching entry.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): a load request (in_kind = 0) writes
//   in_key_value at in_entry_index and gives no result; a search request
//   (in_kind = 1) gives one result on the output channel.
//   Output channel (out_valid / out_stall): out_found and out_position; the
//   position reads zero when the key is not found.
//   Configuration (cfg_valid / cfg_ready): cfg_entry_count sets how many
//   entries, from index zero, a search covers; counts above TABLE_DEPTH are
//   clamped. Write it only while no search is in flight.
// Timing:
//   A load writes the key memory as it is taken. A search makes one read of
//   the key memory per probe, up to ceil(log2(count+1)) probes, and its result
//   then enters the output register. With an empty table no probe is made and
//   the result passes through ST_DONE into the output register.
//   The next request is taken once the result has entered the output register,
//   even if the receiver still stalls it. A result that cannot enter the
//   output register is held and the input stalls until it can.
// Reset (rst_n, synchronous): clears the entry count, the controller and the
//   output valid. The key memory is not cleared; entries read as undefined
//   until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_binary_search_core #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_WIDTH   = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // configuration
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [sts_pkg::COUNT_W-1:0]        cfg_entry_count,
  // request channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               in_kind,
  input  wire logic [sts_pkg::ENTRY_INDEX_W-1:0]  in_entry_index,
  input  wire logic [sts_pkg::KEY_VALUE_W-1:0]    in_key_value,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_found,
  output logic [sts_pkg::POSITION_W-1:0]          out_position
);

  import sts_pkg::*;

  // Address width of the memory, and bound width able to hold TABLE_DEPTH
  localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int BW   = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW = (COUNT_W > BW) ? COUNT_W : BW;
  localparam int IW   = (ENTRY_INDEX_W > BW) ? ENTRY_INDEX_W : BW;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_t                 state_r, state_nxt;
  logic [COUNT_W-1:0]     entry_count_r;
  logic [BW-1:0]          lo_r, lo_nxt;       // inclusive lower bound
  logic [BW-1:0]          hi_r, hi_nxt;       // exclusive upper bound
  logic [BW-1:0]          mid_r, mid_nxt;     // entry being probed
  logic [KEY_WIDTH-1:0]   key_r, key_nxt;     // key sought
  logic                   res_found_r, res_found_nxt;
  logic [POSITION_W-1:0]  res_pos_r, res_pos_nxt;
  logic                   out_valid_r;
  logic                   out_found_r;
  logic [POSITION_W-1:0]  out_position_r;

  // Key memory: one write port, one registered read port
  logic [KEY_WIDTH-1:0]   key_mem [TABLE_DEPTH];
  logic [KEY_WIDTH-1:0]   rd_data_r;
  logic                   mem_we;
  logic                   mem_re;
  logic [AW-1:0]          rd_addr;

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  logic                   in_stall_int;
  logic                   in_accept;
  logic                   idx_in_range;
  logic [KEY_WIDTH-1:0]   in_key_masked;
  logic [BW-1:0]          count_eff;
  logic [BW-1:0]          mid_init;

  // Take requests only between searches
  assign in_stall_int  = (state_r != ST_IDLE);
  assign in_accept     = in_valid && !in_stall_int;
  assign idx_in_range  = IW'(in_entry_index) < IW'(TABLE_DEPTH);
  assign in_key_masked = KEY_WIDTH'(in_key_value);

  // Clamp the configured count to the table depth
  assign count_eff = (CMPW'(entry_count_r) > CMPW'(TABLE_DEPTH)) ?
                     BW'(TABLE_DEPTH) : BW'(entry_count_r);
  // First probe with lo = 0, hi = count
  assign mid_init  = (count_eff - BW'(1)) >> 1;

  // --------------------------------------------------------------------------
  // Probe step: both possible successors are worked out from the registered
  // bounds, so the compare result only has to pick one of them.
  // --------------------------------------------------------------------------
  logic                   probe_hit;
  logic                   probe_gt;
  logic [BW-1:0]          mid_inc;
  logic                   cont_dn, cont_up;
  logic [BW-1:0]          mid_dn, mid_up;
  logic                   cont_sel;
  logic [BW-1:0]          lo_sel, hi_sel, mid_sel;

  assign probe_hit = (rd_data_r == key_r);
  assign probe_gt  = (rd_data_r > key_r);
  assign mid_inc   = mid_r + BW'(1);

  // Probed key greater: upper bound drops to the probe
  assign cont_dn = lo_r < mid_r;
  assign mid_dn  = lo_r + ((mid_r - BW'(1) - lo_r) >> 1);
  // Otherwise: lower bound moves past the probe
  assign cont_up = mid_inc < hi_r;
  assign mid_up  = mid_inc + ((hi_r - BW'(1) - mid_inc) >> 1);

  assign cont_sel = probe_gt ? cont_dn : cont_up;
  assign lo_sel   = probe_gt ? lo_r    : mid_inc;
  assign hi_sel   = probe_gt ? mid_r   : hi_r;
  assign mid_sel  = probe_gt ? mid_dn  : mid_up;

  // --------------------------------------------------------------------------
  // Controller outputs: handshakes, memory port, result hand-over
  // --------------------------------------------------------------------------
  logic                   out_free;
  logic                   out_load;
  logic                   res_found_sel;
  logic [POSITION_W-1:0]  res_pos_sel;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    mem_we        = in_accept && (in_kind == KIND_LOAD) && idx_in_range;
    mem_re        = 1'b0;
    rd_addr       = '0;
    out_load      = 1'b0;
    res_found_sel = res_found_r;
    res_pos_sel   = res_pos_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept && (in_kind == KIND_SEARCH) && (count_eff != '0)) begin
          mem_re  = 1'b1;
          rd_addr = AW'(mid_init);
        end
      end
      ST_PROBE: begin
        if (!probe_hit && cont_sel) begin
          mem_re  = 1'b1;
          rd_addr = AW'(mid_sel);
        end else begin
          // search ends here: hand over at once if the output slot is free
          out_load      = out_free;
          res_found_sel = probe_hit;
          res_pos_sel   = probe_hit ? POSITION_W'(mid_r) : '0;
        end
      end
      ST_DONE: begin
        out_load = out_free;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Controller next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    res_found_nxt = res_found_r;
    res_pos_nxt   = res_pos_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept && (in_kind == KIND_SEARCH)) begin
          key_nxt = in_key_masked;
          if (count_eff == '0) begin
            // empty table: not found, no probe
            res_found_nxt = 1'b0;
            res_pos_nxt   = '0;
            state_nxt     = ST_DONE;
          end else begin
            lo_nxt    = '0;
            hi_nxt    = count_eff;
            mid_nxt   = mid_init;
            state_nxt = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        if (!probe_hit && cont_sel) begin
          lo_nxt  = lo_sel;
          hi_nxt  = hi_sel;
          mid_nxt = mid_sel;
        end else begin
          res_found_nxt = res_found_sel;
          res_pos_nxt   = res_pos_sel;
          state_nxt     = out_free ? ST_IDLE : ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      entry_count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        entry_count_r <= cfg_entry_count;
      end
    end
  end

  // Search datapath: no reset needed
  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    key_r       <= key_nxt;
    res_found_r <= res_found_nxt;
    res_pos_r   <= res_pos_nxt;
  end

  // Output register: load a result, drop valid once taken, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r    <= res_found_sel;
      out_position_r <= res_pos_sel;
    end
  end

  // Key memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[AW'(in_entry_index)] <= in_key_masked;
    end
    if (mem_re) begin
      rd_data_r <= key_mem[rd_addr];
    end
  end

  assign cfg_ready    = (state_r == ST_IDLE);
  assign in_stall     = in_stall_int;
  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_position_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTH
  // A probe always has a non-empty search range
  a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE) |-> (lo_r < hi_r))
    else $error("probe with empty search range");

  // The probed entry lies inside the current bounds
  a_probe_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE) |-> ((mid_r >= lo_r) && (mid_r < hi_r)))
    else $error("probe position outside bounds");

  // The search never reaches past the clamped entry count
  a_probe_hi: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE) |-> (hi_r <= count_eff))
    else $error("upper bound beyond entry count");

  // The memory port never reads and writes in the same cycle
  a_mem_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("memory read and write together");

  // A new result only ever appears at the end of a search
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_PROBE || $past(state_r) == ST_DONE))
    else $error("result without a search");
`endif

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb : request-level bench for the sorted-table binary search core
// Loads key tables through the request channel, sets the entry count through
// the configuration port and fires search requests at them. Every search
// answer is predicted from a mirror of the key table or typed in, and checked
// field by field, in order, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sts_pkg::*;

  localparam int TABLE_DEPTH  = 1024;
  localparam int ITEM_TARGET  = 1800;
  localparam int DRAIN_CYCLES = 16;      // covers one full 1024-entry search plus margin
  localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int OPENING_ROWS = 22;

  typedef struct packed {
    logic                  found;
    logic [POSITION_W-1:0] position;
  } search_answer_t;

  // One row of the opening sequence: an optional entry count write, then one
  // request, with the answer typed in where it is obvious.
  typedef struct packed {
    bit                       set_count;
    logic [COUNT_W-1:0]       count;
    logic                     kind;
    logic [ENTRY_INDEX_W-1:0] idx;
    logic [KEY_VALUE_W-1:0]   key;
    bit                       typed;
    search_answer_t           answer;
  } opening_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [COUNT_W-1:0]       cfg_entry_count;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_kind;
  logic [ENTRY_INDEX_W-1:0] in_entry_index;
  logic [KEY_VALUE_W-1:0]   in_key_value;
  logic                     out_valid;
  logic                     out_stall;
  logic                     out_found;
  logic [POSITION_W-1:0]    out_position;

  // Mirror of the block: key table, which entries were ever loaded, and the
  // entry count as last written.
  logic [KEY_VALUE_W-1:0] key_mirror [TABLE_DEPTH];
  bit                     loaded     [TABLE_DEPTH];
  int unsigned            entry_limit;

  search_answer_t search_answers [$];  // answers still owed by the block
  opening_row_t   opening_requests [OPENING_ROWS];

  int unsigned requests_taken;
  int unsigned fault_count;
  int unsigned cycle_count;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;

  // Hold-off hand-over to the receiver process: toggle hold_arm to start one.
  bit          hold_arm;
  bit          hold_seen;
  int unsigned hold_left;

  sorted_table_binary_search_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_entry_count (cfg_entry_count),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_entry_index  (in_entry_index),
    .in_key_value    (in_key_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_position    (out_position)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Binary search over the mirror, probing at lo + (hi - 1 - lo) / 2 with an
  // exclusive upper bound; counts above the table depth are clamped.
  function automatic search_answer_t predict_search(input logic [KEY_VALUE_W-1:0] key);
    int unsigned    lo;
    int unsigned    hi;
    int unsigned    mid;
    search_answer_t ans;
    ans = '0;
    lo  = 0;
    hi  = (entry_limit > TABLE_DEPTH) ? TABLE_DEPTH : entry_limit;
    while (lo < hi) begin
      mid = lo + (hi - 1 - lo) / 2;
      if (key_mirror[mid] == key) begin
        ans.found    = 1'b1;
        ans.position = mid[POSITION_W-1:0];
        return ans;
      end
      if (key_mirror[mid] > key) hi = mid;
      else lo = mid + 1;
    end
    return ans;
  endfunction

  // Offer one request, hold it until accepted, then update the mirror or
  // queue the answer. Returns at the falling edge after acceptance with
  // in_valid still high, so back-to-back requests keep valid asserted.
  task automatic send_request(input logic kind, input logic [ENTRY_INDEX_W-1:0] idx,
                              input logic [KEY_VALUE_W-1:0] key, input bit typed,
                              input search_answer_t typed_answer);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_entry_index <= idx;
    in_key_value   <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_taken++;
    if (kind == KIND_LOAD) begin
      key_mirror[idx] = key;
      loaded[idx]     = 1'b1;
    end else begin
      search_answers.push_back(typed ? typed_answer : predict_search(key));
    end
    @(negedge clk);
  endtask

  // Write the entry count once the block has gone quiet: drop valid, wait for
  // every owed answer, then let a trailing load or search finish.
  task automatic write_entry_count(input logic [COUNT_W-1:0] value);
    in_valid <= 1'b0;
    while (search_answers.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid       <= 1'b1;
    cfg_entry_count <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    entry_limit = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One random phase: pick an idle mode and an entry count, reload the table where
  // needed, mostly with ascending keys, then run searches with some noise loads.
  task automatic run_phase(input int unsigned phase_no);
    int unsigned            pick;
    int unsigned            span;
    int unsigned            n;
    int unsigned            i;
    int unsigned            step_max;
    bit                     reload;
    bit                     messy;
    logic [COUNT_W-1:0]     count;
    logic [KEY_VALUE_W:0]   run_key;
    logic [KEY_VALUE_W-1:0] key;
    search_answer_t         none;
    none = '0;

    case (phase_no % 4)
      0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_idle_pct = 87; sink_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  sink_stall_pct = 87; end
      default: begin src_idle_pct = 16; sink_stall_pct = 16; end
    endcase

    // Force the full table and the clamped maximum early on; mostly small tables
    // otherwise, since they are cheap to reload.
    pick = $urandom_range(99);
    if (phase_no == 1) count = COUNT_W'(TABLE_DEPTH);
    else if (phase_no == 2) count = '1;
    else if (phase_no == 3) count = COUNT_W'(16);
    else if (pick < 6) count = '0;
    else if (pick < 12) count = COUNT_W'(1);
    else if (pick < 15) count = COUNT_W'($urandom_range(2047, TABLE_DEPTH - 32));
    else count = COUNT_W'($urandom_range(48, 2));
    span = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;

    write_entry_count(count);

    // Hold the result channel off for a long stretch so that the core fills
    // and stalls its request channel while requests keep coming.
    if (phase_no == 3) hold_arm = ~hold_arm;

    // Reload small tables every time; large ones only when some entry in
    // range was never loaded, so no search can touch an unwritten entry.
    reload = (span <= 64);
    for (i = 0; i < span; i++)
      if (!loaded[i]) reload = 1'b1;

    if (reload && span != 0) begin
      messy = ($urandom_range(9) == 0);
      pick  = $urandom_range(2);
      if (pick == 0) step_max = 2;          // dense, many duplicates
      else if (pick == 1) step_max = 1000;
      else step_max = 32'hFFFF_FFFF / span; // spread over the whole key range
      run_key = ($urandom_range(3) == 0) ? '0 : (KEY_VALUE_W+1)'($urandom_range(step_max));
      for (i = 0; i < span; i++) begin
        if (messy) key = $urandom;
        else if (run_key[KEY_VALUE_W]) key = '1;
        else key = run_key[KEY_VALUE_W-1:0];
        send_request(KIND_LOAD, ENTRY_INDEX_W'(i), key, 1'b0, none);
        run_key = run_key[KEY_VALUE_W] ? run_key : run_key + $urandom_range(step_max);
      end
    end

    n = $urandom_range(60, 20);
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_request(KIND_LOAD, ENTRY_INDEX_W'($urandom_range(TABLE_DEPTH - 1)), $urandom,
                     1'b0, none);
      end else begin
        if (span != 0 && pick < 60) begin
          key = key_mirror[$urandom_range(span - 1)];
        end else if (span != 0 && pick < 75) begin
          key = key_mirror[$urandom_range(span - 1)];
          key = $urandom_range(1) ? key + 1'b1 : key - 1'b1;
        end else if (pick < 80) begin
          key = '0;
        end else if (pick < 85) begin
          key = '1;
        end else begin
          key = $urandom;
        end
        send_request(KIND_SEARCH, ENTRY_INDEX_W'($urandom_range(TABLE_DEPTH - 1)), key,
                     1'b0, none);
      end
    end
  endtask

  // Receiver: stall at random, or hold off for a counted stretch when armed.
  always @(negedge clk) begin
    if (hold_arm != hold_seen) begin
      hold_seen = hold_arm;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (sink_stall_pct != 0) && ($urandom_range(99) < sink_stall_pct);
    end
  end

  // Answer checker: compare each accepted answer with the oldest one owed.
  always @(posedge clk) begin : answer_check
    search_answer_t got;
    search_answer_t due;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_found, out_position};
      if (search_answers.size() == 0) begin
        if (fault_count < 10)
          $display("%0t: answer with none owed: found %b position %0d",
                   $realtime, out_found, out_position);
        fault_count++;
      end else begin
        due = search_answers.pop_front();
        if (got !== due) begin
          if (fault_count < 10)
            $display("%0t: answer mismatch: found %b/%b position %0d/%0d (exp/got)",
                     $realtime, due.found, got.found, due.position, got.position);
          fault_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned row;
    int unsigned phase_no;

    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_entry_count = '0;
    in_valid        = 1'b0;
    in_kind         = KIND_LOAD;
    in_entry_index  = '0;
    in_key_value    = '0;
    out_stall       = 1'b0;
    hold_arm        = 1'b0;
    hold_seen       = 1'b0;
    hold_left       = 0;
    entry_limit     = 0;
    src_idle_pct    = 0;
    sink_stall_pct  = 0;
    requests_taken  = 0;
    fault_count     = 0;
    cycle_count     = 0;
    foreach (loaded[i]) loaded[i] = 1'b0;

    // Opening sequence: empty table after reset, table with the key extremes
    // and a run of duplicates, top entry index, single entry, empty count,
    // then an out-of-order entry.
    opening_requests[0]  = '{1'b0, 11'd0, KIND_SEARCH, 10'd0, 32'd5, 1'b1, '{1'b0, 10'd0}};
    opening_requests[1]  = '{1'b0, 11'd0, KIND_LOAD, 10'd0, 32'h0000_0000, 1'b0, '0};
    opening_requests[2]  = '{1'b0, 11'd0, KIND_LOAD, 10'd1, 32'h0000_0003, 1'b0, '0};
    opening_requests[3]  = '{1'b0, 11'd0, KIND_LOAD, 10'd2, 32'h0000_0003, 1'b0, '0};
    opening_requests[4]  = '{1'b0, 11'd0, KIND_LOAD, 10'd3, 32'h0000_0003, 1'b0, '0};
    opening_requests[5]  = '{1'b0, 11'd0, KIND_LOAD, 10'd4, 32'h0000_0064, 1'b0, '0};
    opening_requests[6]  = '{1'b0, 11'd0, KIND_LOAD, 10'd5, 32'h7FFF_FFFF, 1'b0, '0};
    opening_requests[7]  = '{1'b0, 11'd0, KIND_LOAD, 10'd6, 32'hFFFF_FFFE, 1'b0, '0};
    opening_requests[8]  = '{1'b0, 11'd0, KIND_LOAD, 10'd7, 32'hFFFF_FFFF, 1'b0, '0};
    opening_requests[9]  = '{1'b0, 11'd0, KIND_LOAD, 10'd1023, 32'hA5A5_A5A5, 1'b0, '0};
    opening_requests[10] = '{1'b1, 11'd8, KIND_SEARCH, 10'd0, 32'h0000_0000, 1'b1,
                             '{1'b1, 10'd0}};
    opening_requests[11] = '{1'b0, 11'd0, KIND_SEARCH, 10'd1023, 32'hFFFF_FFFF, 1'b1,
                             '{1'b1, 10'd7}};
    opening_requests[12] = '{1'b0, 11'd0, KIND_SEARCH, 10'd0, 32'h0000_0003, 1'b0, '0};
    opening_requests[13] = '{1'b0, 11'd0, KIND_SEARCH, 10'd0, 32'h0000_0032, 1'b1,
                             '{1'b0, 10'd0}};
    opening_requests[14] = '{1'b0, 11'd0, KIND_SEARCH, 10'd0, 32'h8000_0000, 1'b0, '0};
    opening_requests[15] = '{1'b0, 11'd0, KIND_SEARCH, 10'd0, 32'h0000_0064, 1'b0, '0};
    opening_requests[16] = '{1'b1, 11'd1, KIND_SEARCH, 10'd0, 32'h0000_0000, 1'b0, '0};
    opening_requests[17] = '{1'b0, 11'd0, KIND_SEARCH, 10'd0, 32'h0000_0003, 1'b1,
                             '{1'b0, 10'd0}};
    opening_requests[18] = '{1'b1, 11'd0, KIND_SEARCH, 10'd0, 32'h0000_0000, 1'b1,
                             '{1'b0, 10'd0}};
    opening_requests[19] = '{1'b0, 11'd0, KIND_LOAD, 10'd3, 32'h0000_00C8, 1'b0, '0};
    opening_requests[20] = '{1'b1, 11'd8, KIND_SEARCH, 10'd0, 32'h0000_0064, 1'b0, '0};
    opening_requests[21] = '{1'b0, 11'd0, KIND_SEARCH, 10'd0, 32'h0000_00C8, 1'b0, '0};

    // Hold reset, then release it at a falling edge.
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (row = 0; row < OPENING_ROWS; row++) begin
      if (opening_requests[row].set_count)
        write_entry_count(opening_requests[row].count);
      send_request(opening_requests[row].kind, opening_requests[row].idx,
                   opening_requests[row].key, opening_requests[row].typed,
                   opening_requests[row].answer);
    end

    phase_no = 0;
    while (requests_taken < ITEM_TARGET) begin
      run_phase(phase_no);
      phase_no++;
    end

    // Drain: drop valid, collect every owed answer, then watch for strays.
    in_valid <= 1'b0;
    while (search_answers.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fault_count == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
